// File: rtl/rfrs_pkg.sv
package rfrs_pkg;

  // fixed field widths
  localparam int TOL_W  = 47;
  localparam int ITER_W = 10;
  localparam int STAT_W = 2;

  // parameter defaults
  localparam int DEF_VALUE_W  = 48;
  localparam int DEF_MAX_ITER = 1023;

  // op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_EVAL = 2'd0;
  localparam logic [STAT_W-1:0] ST_ROOT = 2'd1;
  localparam logic [STAT_W-1:0] ST_NA   = 2'd2;
  localparam logic [STAT_W-1:0] ST_CAP  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic load;
    logic mul_step;
    logic div_step;
    logic finish;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_chord;
  } stat_t;

endpackage

// File: rtl/rfrs_ctrl.sv
module rfrs_ctrl #(
  parameter int VALUE_W = rfrs_pkg::DEF_VALUE_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  rfrs_pkg::stat_t stat,
  output rfrs_pkg::cmd_t  cmd
);

  localparam int CNT_W = $clog2(VALUE_W + 2);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept, can_emit, last_step;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_emit  = !out_valid || !out_stall;
  assign last_step = (cnt == CNT_W'(VALUE_W));

  // next state and commands
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.accept   = accept;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = stat.need_chord ? S_LOAD : S_EMIT;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = last_step ? '0 : cnt + 1'b1;
        if (last_step) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = last_step ? '0 : cnt + 1'b1;
        if (last_step) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_emit) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/rfrs_dp.sv
module rfrs_dp #(
  parameter int VALUE_W  = rfrs_pkg::DEF_VALUE_W,
  parameter int MAX_ITER = rfrs_pkg::DEF_MAX_ITER
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rfrs_pkg::cmd_t                    cmd,
  output rfrs_pkg::stat_t                   stat,
  input  logic                              tolerance_we,
  input  logic [rfrs_pkg::TOL_W-1:0]        tolerance_wdata,
  input  logic                              op,
  input  logic signed [VALUE_W-1:0]         left_end,
  input  logic signed [VALUE_W-1:0]         right_end,
  input  logic signed [VALUE_W-1:0]         left_value,
  input  logic signed [VALUE_W-1:0]         right_value,
  input  logic signed [VALUE_W-1:0]         point_value,
  output logic [rfrs_pkg::STAT_W-1:0]       status,
  output logic signed [VALUE_W-1:0]         point,
  output logic [rfrs_pkg::ITER_W-1:0]       iterations
);

  localparam int W   = VALUE_W;
  localparam int DW  = W + 1;
  localparam int CW  = (DW > rfrs_pkg::TOL_W) ? DW : rfrs_pkg::TOL_W;

  // algorithm state
  logic [rfrs_pkg::TOL_W-1:0]  tol;
  logic signed [W-1:0]         bl, br, vl, vr, cf, cs, cc;
  logic                        wr_second, left_pos, running;
  logic [rfrs_pkg::ITER_W-1:0] step_count;

  // pending result word
  logic [rfrs_pkg::STAT_W-1:0] res_status;
  logic signed [W-1:0]         res_point;
  logic [rfrs_pkg::ITER_W-1:0] res_iter;

  // multiply/divide registers; hi and lo are shared by both
  logic [W:0] span, mreg, hi, lo, den;
  logic       dir;

  // magnitude helpers
  logic [W-1:0] mag_fa, mag_fb, mag_fc, mag_vl, mag_vr;
  always_comb begin
    mag_fa = left_value[W-1]  ? W'(-left_value)  : W'(left_value);
    mag_fb = right_value[W-1] ? W'(-right_value) : W'(right_value);
    mag_fc = point_value[W-1] ? W'(-point_value) : W'(point_value);
    mag_vl = vl[W-1] ? W'(-vl) : W'(vl);
    mag_vr = vr[W-1] ? W'(-vr) : W'(vr);
  end

  logic small_fa, small_fb, small_fc;
  assign small_fa = CW'(mag_fa) < CW'(tol);
  assign small_fb = CW'(mag_fb) < CW'(tol);
  assign small_fc = CW'(mag_fc) < CW'(tol);

  // spacing checks
  logic signed [W:0] ab_diff, cc_diff;
  logic [W:0]        ab_abs, cc_abs;
  logic              ab_close, cc_close;
  always_comb begin
    ab_diff  = DW'(right_end) - DW'(left_end);
    ab_abs   = ab_diff[W] ? DW'(-ab_diff) : DW'(ab_diff);
    ab_close = CW'(ab_abs) <= CW'(tol);
    cc_diff  = DW'(cs) - DW'(cf);
    cc_abs   = cc_diff[W] ? DW'(-cc_diff) : DW'(cc_diff);
    cc_close = CW'(cc_abs) <= CW'(tol);
  end

  // decision on an accepted word
  logic                        no_change, val_left, at_cap;
  logic [rfrs_pkg::STAT_W-1:0] dec_status;
  logic signed [W-1:0]         dec_point;
  logic [rfrs_pkg::ITER_W-1:0] dec_iter;
  always_comb begin
    no_change = (left_value == '0) || (right_value == '0) ||
                (left_value[W-1] == right_value[W-1]);
    val_left  = (point_value != '0) && (!point_value[W-1] == left_pos);
    at_cap    = 32'(step_count) >= 32'(MAX_ITER);
    stat.need_chord = 1'b0;
    dec_status = rfrs_pkg::ST_NA;
    dec_point  = '0;
    dec_iter   = '0;
    if (op == rfrs_pkg::OP_START) begin
      if (small_fa) begin
        dec_status = rfrs_pkg::ST_ROOT;
        dec_point  = left_end;
        dec_iter   = rfrs_pkg::ITER_W'(1);
      end else if (small_fb) begin
        dec_status = rfrs_pkg::ST_ROOT;
        dec_point  = right_end;
        dec_iter   = rfrs_pkg::ITER_W'(1);
      end else if (no_change) begin
        dec_status = rfrs_pkg::ST_NA;
      end else if (ab_close) begin
        dec_status = rfrs_pkg::ST_ROOT;
        dec_point  = left_end;
      end else begin
        stat.need_chord = 1'b1;
      end
    end else if (running) begin
      if (small_fc || cc_close) begin
        dec_status = rfrs_pkg::ST_ROOT;
        dec_point  = cc;
        dec_iter   = step_count;
      end else if (at_cap) begin
        dec_status = rfrs_pkg::ST_CAP;
        dec_point  = cc;
        dec_iter   = step_count;
      end else begin
        stat.need_chord = 1'b1;
      end
    end
  end

  // one step of the shift-add multiplier and of the restoring divider
  logic [W+1:0] mul_sum, div_t, div_d;
  logic         div_ge;
  always_comb begin
    mul_sum = {1'b0, hi} + (mreg[0] ? {1'b0, span} : '0);
    div_t   = {hi, lo[W]};
    div_ge  = div_t >= {1'b0, den};
    div_d   = div_t - {1'b0, den};
  end

  // new chord point
  logic [W:0]   off;
  logic [W:0]   c_wide;
  logic [W-1:0] c_new;
  always_comb begin
    off    = (den == '0) ? '0 : lo;
    c_wide = dir ? DW'(bl) + off : DW'(bl) - off;
    c_new  = c_wide[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol        <= rfrs_pkg::TOL_W'(1);
      bl         <= '0;
      br         <= '0;
      vl         <= '0;
      vr         <= '0;
      cf         <= '0;
      cs         <= '0;
      cc         <= '0;
      wr_second  <= 1'b0;
      left_pos   <= 1'b0;
      running    <= 1'b0;
      step_count <= '0;
    end else begin
      if (tolerance_we) tol <= tolerance_wdata;

      // state update on an accepted word
      if (cmd.accept) begin
        res_status <= dec_status;
        res_point  <= dec_point;
        res_iter   <= dec_iter;
        if (op == rfrs_pkg::OP_START) begin
          running    <= 1'b0;
          step_count <= '0;
          if (!small_fa && !small_fb && !no_change) begin
            bl        <= left_end;
            br        <= right_end;
            vl        <= left_value;
            vr        <= right_value;
            left_pos  <= !left_value[W-1];
            cf        <= left_end;
            cs        <= right_end;
            cc        <= left_end;
            wr_second <= 1'b0;
          end
        end else if (running) begin
          if (small_fc) begin
            running <= 1'b0;
          end else begin
            if (val_left) begin
              bl <= cc;
              vl <= point_value;
            end else begin
              br <= cc;
              vr <= point_value;
            end
            if (cc_close || at_cap) running <= 1'b0;
          end
        end
      end

      // chord point commit
      if (cmd.finish) begin
        step_count <= step_count + 1'b1;
        if (wr_second) cs <= c_new;
        else cf <= c_new;
        wr_second  <= !wr_second;
        cc         <= c_new;
        running    <= 1'b1;
        res_status <= rfrs_pkg::ST_EVAL;
        res_point  <= c_new;
        res_iter   <= step_count + 1'b1;
      end
    end
  end

  // arithmetic unit, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span <= (br >= bl) ? DW'(br) - DW'(bl) : DW'(bl) - DW'(br);
      dir  <= (br >= bl);
      mreg <= {1'b0, mag_vl};
      den  <= DW'(mag_vl) + DW'(mag_vr);
      hi   <= '0;
      lo   <= '0;
    end else if (cmd.mul_step) begin
      hi   <= mul_sum[W+1:1];
      lo   <= {mul_sum[0], lo[W:1]};
      mreg <= mreg >> 1;
    end else if (cmd.div_step) begin
      hi <= div_ge ? div_d[W:0] : div_t[W:0];
      lo <= {lo[W-1:0], div_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status     <= res_status;
      point      <= res_point;
      iterations <= res_iter;
    end
  end

endmodule

// File: rtl/regula_falsi_root_step.sv
// Regula falsi root finder in signed Q16.32. A start word gives the bracket
// ends and the function values there; the block answers with a root, "not
// applicable", or a point at which the caller must evaluate the function and
// send the value back. A word that needs a new chord point passes through a
// serial shift-add multiplier and a restoring divider that share one
// register pair, one bit per cycle each; any other word skips both. One word
// is in work at a time, and a new word is taken while the last result still
// waits at the output.
module regula_falsi_root_step #(
  parameter int MAX_ITERATIONS = rfrs_pkg::DEF_MAX_ITER,
  parameter int VALUE_WIDTH    = rfrs_pkg::DEF_VALUE_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tolerance_we,
  input  logic [rfrs_pkg::TOL_W-1:0]        tolerance_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic signed [VALUE_WIDTH-1:0]     left_end,
  input  logic signed [VALUE_WIDTH-1:0]     right_end,
  input  logic signed [VALUE_WIDTH-1:0]     left_value,
  input  logic signed [VALUE_WIDTH-1:0]     right_value,
  input  logic signed [VALUE_WIDTH-1:0]     point_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rfrs_pkg::STAT_W-1:0]       status,
  output logic signed [VALUE_WIDTH-1:0]     point,
  output logic [rfrs_pkg::ITER_W-1:0]       iterations
);

  rfrs_pkg::cmd_t  cmd;
  rfrs_pkg::stat_t stat;

  rfrs_ctrl #(.VALUE_W(VALUE_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfrs_dp #(.VALUE_W(VALUE_WIDTH), .MAX_ITER(MAX_ITERATIONS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .tolerance_we    (tolerance_we),
    .tolerance_wdata (tolerance_wdata),
    .op              (op),
    .left_end        (left_end),
    .right_end       (right_end),
    .left_value      (left_value),
    .right_value     (right_value),
    .point_value     (point_value),
    .status          (status),
    .point           (point),
    .iterations      (iterations)
  );

  // an accepted word blocks the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a chord request always carries a nonzero step count
  a_eval_iter: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rfrs_pkg::ST_EVAL |-> iterations != '0)
    else $error("chord request with zero iterations");

  // not applicable reports a zero point and count
  a_na_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rfrs_pkg::ST_NA |-> point == '0 && iterations == '0)
    else $error("not applicable word with nonzero fields");

endmodule

// File: test/rfrs_checker.sv
// Watches both channels of the root finder, predicts each result word from
// the accepted input word and compares it with what comes out.
module rfrs_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tolerance_we,
  input  logic [rfrs_pkg::TOL_W-1:0]    tolerance_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          op,
  input  logic signed [47:0]            left_end,
  input  logic signed [47:0]            right_end,
  input  logic signed [47:0]            left_value,
  input  logic signed [47:0]            right_value,
  input  logic signed [47:0]            point_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [rfrs_pkg::STAT_W-1:0]   status,
  input  logic signed [47:0]            point,
  input  logic [rfrs_pkg::ITER_W-1:0]   iterations,
  output int                            fail_count,
  output int                            pending,
  output int                            root_count,
  output int                            cap_count
);

  localparam int MAXIT = rfrs_pkg::DEF_MAX_ITER;

  typedef struct {
    logic [rfrs_pkg::STAT_W-1:0] st;
    logic [47:0]                 pt;
    logic [rfrs_pkg::ITER_W-1:0] it;
  } answer_t;

  answer_t answers_due[$];

  // predictor state
  logic [46:0] tol;
  logic signed [47:0] br_l, br_r, fv_l, fv_r, ch_a, ch_b, ch_cur;
  logic wr_b, l_pos, busy;
  int unsigned steps;

  function automatic logic [47:0] magn(logic signed [47:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic is_small(logic signed [47:0] v);
    return {1'b0, magn(v)} < {2'b0, tol};
  endfunction

  function automatic logic [48:0] span(logic signed [47:0] x, logic signed [47:0] y);
    logic signed [48:0] d;
    d = x - y;
    return d < 0 ? -d : d;
  endfunction

  function automatic logic signed [47:0] chord_pt();
    logic [48:0] den;
    logic [96:0] prod;
    logic [48:0] off;
    den = magn(fv_l) + magn(fv_r);
    prod = span(br_r, br_l) * magn(fv_l);
    off = den == 0 ? 0 : prod / den;
    return br_r >= br_l ? br_l + off[47:0] : br_l - off[47:0];
  endfunction

  function automatic answer_t mk(logic [rfrs_pkg::STAT_W-1:0] s, logic [47:0] p,
                                 int unsigned i);
    answer_t a;
    a.st = s; a.pt = p; a.it = i[rfrs_pkg::ITER_W-1:0];
    return a;
  endfunction

  function automatic answer_t advance_chord();
    logic signed [47:0] c;
    c = chord_pt();
    steps++;
    if (wr_b) ch_b = c; else ch_a = c;
    wr_b = !wr_b;
    ch_cur = c;
    busy = 1;
    return mk(rfrs_pkg::ST_EVAL, c, steps);
  endfunction

  function automatic answer_t predict_answer();
    logic signed [47:0] c;
    if (op == rfrs_pkg::OP_START) begin
      busy = 0;
      steps = 0;
      if (is_small(left_value)) return mk(rfrs_pkg::ST_ROOT, left_end, 1);
      if (is_small(right_value)) return mk(rfrs_pkg::ST_ROOT, right_end, 1);
      if (left_value == 0 || right_value == 0 || (left_value < 0) == (right_value < 0))
        return mk(rfrs_pkg::ST_NA, 0, 0);
      br_l = left_end; br_r = right_end; fv_l = left_value; fv_r = right_value;
      l_pos = left_value >= 0;
      ch_a = left_end; ch_b = right_end; ch_cur = left_end; wr_b = 0;
      if (span(ch_a, ch_b) <= {2'b0, tol}) return mk(rfrs_pkg::ST_ROOT, left_end, 0);
      return advance_chord();
    end
    if (!busy) return mk(rfrs_pkg::ST_NA, 0, 0);
    c = ch_cur;
    if (is_small(point_value)) begin
      busy = 0;
      return mk(rfrs_pkg::ST_ROOT, c, steps);
    end
    if (point_value != 0 && (point_value >= 0) == l_pos) begin
      br_l = c; fv_l = point_value;
    end else begin
      br_r = c; fv_r = point_value;
    end
    if (span(ch_a, ch_b) <= {2'b0, tol}) begin
      busy = 0;
      return mk(rfrs_pkg::ST_ROOT, c, steps);
    end
    if (steps >= MAXIT) begin
      busy = 0;
      return mk(rfrs_pkg::ST_CAP, c, steps);
    end
    return advance_chord();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  assign pending = answers_due.size();

  always @(posedge clk) begin
    answer_t a;
    if (rst) begin
      tol = 1; br_l = 0; br_r = 0; fv_l = 0; fv_r = 0;
      ch_a = 0; ch_b = 0; ch_cur = 0; wr_b = 0; l_pos = 0; busy = 0; steps = 0;
      answers_due.delete();
      fail_count = 0; root_count <= 0; cap_count <= 0;
    end else begin
      // compare the outgoing word first, then predict from the incoming one
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected word", 64'(status), 64'(0));
        end else begin
          a = answers_due.pop_front();
          if (status != a.st) report_mismatch("status", 64'(status), 64'(a.st));
          if (point !== a.pt) report_mismatch("point", 64'(point), 64'(a.pt));
          if (iterations != a.it) report_mismatch("iterations", 64'(iterations), 64'(a.it));
          if (a.st == rfrs_pkg::ST_ROOT) root_count <= root_count + 1;
          if (a.st == rfrs_pkg::ST_CAP) cap_count <= cap_count + 1;
        end
      end
      // a word taken at this edge still sees the old tolerance
      if (in_valid && !in_stall) answers_due.push_back(predict_answer());
      if (tolerance_we) tol = tolerance_wdata;
    end
  end
endmodule

// File: test/tb_top.sv
// Stimulus and verdict for the root finder; checking lives in rfrs_checker.
module tb_top;

  logic clk, rst;
  logic tolerance_we;
  logic [rfrs_pkg::TOL_W-1:0] tolerance_wdata;
  logic in_valid, in_stall, op;
  logic signed [47:0] left_end, right_end, left_value, right_value, point_value;
  logic out_valid, out_stall;
  logic [rfrs_pkg::STAT_W-1:0] status;
  logic signed [47:0] point;
  logic [rfrs_pkg::ITER_W-1:0] iterations;
  int fail_count, pending, root_count, cap_count;
  int send_idle, recv_idle;
  int word_count;

  regula_falsi_root_step dut (
    .clk(clk), .rst(rst),
    .tolerance_we(tolerance_we), .tolerance_wdata(tolerance_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .left_end(left_end), .right_end(right_end),
    .left_value(left_value), .right_value(right_value),
    .point_value(point_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .point(point), .iterations(iterations)
  );

  rfrs_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // timeout
  initial begin
    #30000000;
    $display("regula_falsi_root_step regression: fail");
    $finish;
  end

  // receiver stall
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  function automatic logic signed [47:0] rand48();
    case ($urandom_range(5))
      0: return 48'sh7fffffffffff;
      1: return 48'sh800000000000;
      2: return $signed(48'($urandom_range(255)) - 48'd128);
      3: return 48'({$urandom, $urandom} >>> $urandom_range(40));
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // one word on the input channel, held until taken; driven at the falling edge
  task automatic send_word(logic o, logic signed [47:0] a, logic signed [47:0] b,
                           logic signed [47:0] fa, logic signed [47:0] fb,
                           logic signed [47:0] fc);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_valid = 1; op = o;
    left_end = a; right_end = b; left_value = fa; right_value = fb;
    point_value = fc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    word_count++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending != 0 && guard < 2000000) begin
      @(negedge clk);
      guard++;
    end
    repeat (120) @(negedge clk);
  endtask

  task automatic set_tol(logic [rfrs_pkg::TOL_W-1:0] v);
    drain();
    tolerance_we <= 1; tolerance_wdata <= v;
    @(negedge clk);
    tolerance_we <= 0;
  endtask

  // a well-formed search: start, then values whose sign follows a fake
  // linear function with a root at a random spot
  task automatic search_run(int max_vals);
    logic signed [47:0] a, b, r, fc;
    a = -$signed(48'($urandom_range(1 << 20)) << $urandom_range(20));
    b = $signed(48'($urandom_range(1 << 20)) << $urandom_range(20));
    r = $signed(48'($urandom_range(1000)) - 48'd500);
    send_word(rfrs_pkg::OP_START, a, b, a - r, b - r, rand48());
    for (int k = 0; k < max_vals; k++) begin
      drain();
      if (status != rfrs_pkg::ST_EVAL) break;
      fc = (point - r) >>> $urandom_range(3);
      if ($urandom_range(19) == 0) fc = rand48();
      send_word(rfrs_pkg::OP_VALUE, rand48(), rand48(), rand48(), rand48(), fc);
    end
  endtask

  initial begin
    logic signed [47:0] x;
    int limit;
    rst = 1; tolerance_we = 0; tolerance_wdata = 0; in_valid = 0; op = rfrs_pkg::OP_START;
    left_end = 0; right_end = 0; left_value = 0; right_value = 0; point_value = 0;
    out_stall = 0; send_idle = 0; recv_idle = 0; word_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: idle value, small ends, no sign change, narrow bracket, extremes
    send_word(rfrs_pkg::OP_VALUE, 0, 0, 0, 0, 5);
    send_word(rfrs_pkg::OP_START, 10, 20, 0, 7, 0);
    send_word(rfrs_pkg::OP_START, 10, 20, 7, 0, 0);
    send_word(rfrs_pkg::OP_START, 10, 20, 7, 9, 0);
    send_word(rfrs_pkg::OP_START, 10, 20, -7, -9, 0);
    send_word(rfrs_pkg::OP_START, 10, 11, -7, 9, 0);
    send_word(rfrs_pkg::OP_START, 48'sh800000000000, 48'sh7fffffffffff,
              48'sh800000000000, 48'sh7fffffffffff, 0);
    send_word(rfrs_pkg::OP_VALUE, 0, 0, 0, 0, 48'sh7fffffffffff);
    send_word(rfrs_pkg::OP_VALUE, 0, 0, 0, 0, 48'sh800000000000);
    send_word(rfrs_pkg::OP_START, 48'sh7fffffffffff, 48'sh800000000000,
              48'sh7fffffffffff, -48'sd1, 0);
    send_word(rfrs_pkg::OP_VALUE, 0, 0, 0, 0, -48'sd3);
    set_tol(0);
    send_word(rfrs_pkg::OP_START, 100, 0, 5, -5, 0);
    send_word(rfrs_pkg::OP_VALUE, 0, 0, 0, 0, 0);
    send_word(rfrs_pkg::OP_START, 1000, -1000, -1, 1, 0);
    send_word(rfrs_pkg::OP_VALUE, 0, 0, 0, 0, 0);
    set_tol(47'h7fffffffffff);
    send_word(rfrs_pkg::OP_START, 1, 2, 48'sh7fffffffffff, 3, 0);
    set_tol(1);
    // iteration cap: the left end value stays put, so the chord creeps
    // toward the right end in steps far above the tolerance
    send_word(rfrs_pkg::OP_START, 0, 48'sh010000000000, -48'sh000040000000,
              48'sh7fffffffffff, 0);
    for (int k = 0; k < 1030; k++) begin
      drain();
      if (status == rfrs_pkg::ST_CAP) break;
      send_word(rfrs_pkg::OP_VALUE, 0, 0, 0, 0, -48'sh000040000000);
    end
    drain();

    // random: three idling phases with a tolerance change between
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 11 : ph == 1 ? 78 : 0;
      recv_idle = ph == 0 ? 78 : ph == 1 ? 11 : 0;
      set_tol(ph == 0 ? 47'd1 : ph == 1 ? 47'($urandom_range(1 << 16)) : 47'd0);
      limit = word_count + 150;
      while (word_count < limit) begin
        if ($urandom_range(3) != 0) begin
          search_run(12);
        end else begin
          x = rand48();
          send_word($urandom_range(1), rand48(), rand48(), x, $urandom_range(1) ? -x : rand48(),
                    rand48());
        end
      end
    end
    drain();

    $display("%0d input words, %0d roots, %0d iteration caps", word_count, root_count, cap_count);
    $display("three stall patterns and four tolerance settings applied");
    if (fail_count == 0) begin
      $display("regula_falsi_root_step regression: pass");
    end else begin
      $display("regula_falsi_root_step regression: fail");
    end
    $finish;
  end
endmodule
